/* src/apid_pkg.sv */
// Package for the altitude PID controller.
// Holds state, command, status and register types and the fixed-point constants.
// Depends on nothing; every other file imports it.
package apid_pkg;

  localparam int DATA_W = 32;
  localparam int GAIN_W = 31;
  localparam int Q_FRAC = 16;
  localparam int ADDR_W = 5;
  localparam int PRD_W  = 32;

  localparam logic [GAIN_W-1:0] PERIOD_RESET = 31'd1311;  // 0.02 s
  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MKI,
    ST_SKI,
    ST_MPER,
    ST_SPER,
    ST_INT,
    ST_MKP,
    ST_SKP,
    ST_MKD,
    ST_SKD,
    ST_SUM
  } st_t;

  typedef enum logic [1:0] {
    MS_KI,
    MS_PER,
    MS_KP,
    MS_KD
  } msel_t;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_ILIM,
    REG_CLIM,
    REG_HOVER,
    REG_PERIOD
  } reg_idx_t;

  typedef struct packed {
    logic  in_load;
    logic  err_en;
    logic  mul_en;
    msel_t mul_sel;
    logic  sat_en;
    logic  sat_to_p;
    logic  integ_en;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic [GAIN_W-1:0]        integ_limit;
    logic [GAIN_W-1:0]        command_limit;
    logic signed [DATA_W-1:0] hover_offset;
    logic [GAIN_W-1:0]        sample_period;
  } cfg_regs_t;

endpackage

/* src/apid_if.sv */
// Handshake channel interfaces for the altitude PID controller.
// Depends on apid_pkg for field widths.
interface apid_in_if;
  import apid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target_alt;
  logic signed [DATA_W-1:0] measured_alt;
  logic signed [DATA_W-1:0] climb_rate;

  modport source (output valid, output target_alt, output measured_alt, output climb_rate,
                  input ready);
  modport sink   (input valid, input target_alt, input measured_alt, input climb_rate,
                  output ready);
endinterface

interface apid_out_if;
  import apid_pkg::*;
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] drive_command;
  logic              integ_clamped;
  logic              output_clamped;

  modport source (output valid, output drive_command, output integ_clamped,
                  output output_clamped, input ready);
  modport sink   (input valid, input drive_command, input integ_clamped,
                  input output_clamped, output ready);
endinterface

/* src/apid_regs.sv */
// Configuration register bank with an APB-style write/read port.
// Depends on apid_pkg (register index codes, cfg_regs_t).
module apid_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [apid_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output apid_pkg::cfg_regs_t        cfg
);
  import apid_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_KP:     cfg_nxt.prop_gain     = pwdata[GAIN_W-1:0];
        REG_KI:     cfg_nxt.integ_gain    = pwdata[GAIN_W-1:0];
        REG_KD:     cfg_nxt.deriv_gain    = pwdata[GAIN_W-1:0];
        REG_ILIM:   cfg_nxt.integ_limit   = pwdata[GAIN_W-1:0];
        REG_CLIM:   cfg_nxt.command_limit = pwdata[GAIN_W-1:0];
        REG_HOVER:  cfg_nxt.hover_offset  = pwdata;
        REG_PERIOD: cfg_nxt.sample_period = pwdata[GAIN_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:     prdata = {1'b0, cfg_r.prop_gain};
      REG_KI:     prdata = {1'b0, cfg_r.integ_gain};
      REG_KD:     prdata = {1'b0, cfg_r.deriv_gain};
      REG_ILIM:   prdata = {1'b0, cfg_r.integ_limit};
      REG_CLIM:   prdata = {1'b0, cfg_r.command_limit};
      REG_HOVER:  prdata = cfg_r.hover_offset;
      REG_PERIOD: prdata = {1'b0, cfg_r.sample_period};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.deriv_gain    <= '0;
      cfg_r.integ_limit   <= '0;
      cfg_r.command_limit <= '0;
      cfg_r.hover_offset  <= '0;
      cfg_r.sample_period <= PERIOD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/apid_ctrl.sv */
// Controller FSM: sequences one tick through the shared multiplier and the
// saturate, integrate and sum steps. Depends on apid_pkg.
module apid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  apid_pkg::dp_sts_t  sts,
  output apid_pkg::dp_cmd_t  cmd
);
  import apid_pkg::*;

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MS_KI;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = ST_MKI;
      end
      ST_MKI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_KI;
        state_nxt   = ST_SKI;
      end
      ST_SKI: begin
        cmd.sat_en = 1'b1;
        state_nxt  = ST_MPER;
      end
      ST_MPER: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PER;
        state_nxt   = ST_SPER;
      end
      ST_SPER: begin
        cmd.sat_en = 1'b1;
        state_nxt  = ST_INT;
      end
      ST_INT: begin
        cmd.integ_en = 1'b1;
        state_nxt    = ST_MKP;
      end
      ST_MKP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_KP;
        state_nxt   = ST_SKP;
      end
      ST_SKP: begin
        cmd.sat_en   = 1'b1;
        cmd.sat_to_p = 1'b1;
        state_nxt    = ST_MKD;
      end
      ST_MKD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_KD;
        state_nxt   = ST_SKD;
      end
      ST_SKD: begin
        cmd.sat_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        // hold here while the previous result still sits in the output register
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/apid_dp.sv */
// Datapath: input latch, error, shared 32x32 multiplier, Q16.16 saturation,
// integrator with clamp, command sum/clamp and output register. Depends on apid_pkg.
module apid_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  apid_pkg::dp_cmd_t               cmd,
  output apid_pkg::dp_sts_t               sts,
  input  apid_pkg::cfg_regs_t             cfg,
  input  logic signed [apid_pkg::DATA_W-1:0] target_alt,
  input  logic signed [apid_pkg::DATA_W-1:0] measured_alt,
  input  logic signed [apid_pkg::DATA_W-1:0] climb_rate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [apid_pkg::GAIN_W-1:0]     drive_command,
  output logic                            integ_clamped,
  output logic                            output_clamped
);
  import apid_pkg::*;

  logic signed [DATA_W-1:0]   tgt_r, meas_r, rate_r;
  logic signed [DATA_W-1:0]   err_r, qs_r, p_r, integ_r;
  logic signed [2*PRD_W-1:0]  prod_r;
  logic                       iclamp_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0]          drive_r;
  logic                       ic_out_r, oc_out_r;

  // error
  logic signed [DATA_W:0]     diff;
  logic signed [DATA_W-1:0]   err_nxt;

  // multiplier
  logic [GAIN_W-1:0]          mul_gain;
  logic signed [DATA_W-1:0]   mul_x;
  logic signed [PRD_W-1:0]    mul_a;
  logic signed [2*PRD_W-1:0]  prod_nxt;

  // saturate after the Q16.16 shift (arithmetic shift = floor)
  logic signed [2*PRD_W-1:0]  shifted;
  logic [2*PRD_W-DATA_W:0]    hi_bits;
  logic signed [DATA_W-1:0]   qsat;

  // integrator
  logic signed [DATA_W:0]     isum;
  logic signed [DATA_W:0]     ilim;
  logic signed [DATA_W:0]     iacc;
  logic signed [DATA_W-1:0]   integ_nxt;
  logic                       iclamp_nxt;

  // command
  logic signed [DATA_W+1:0]   csum;
  logic signed [DATA_W+1:0]   clim;
  logic [GAIN_W-1:0]          drive_nxt;
  logic                       oclamp_nxt;

  assign diff    = {tgt_r[DATA_W-1], tgt_r} - {meas_r[DATA_W-1], meas_r};
  assign err_nxt = (diff[DATA_W] != diff[DATA_W-1]) ?
                   (diff[DATA_W] ? Q_MIN : Q_MAX) : diff[DATA_W-1:0];

  always_comb begin
    case (cmd.mul_sel)
      MS_KI:   begin mul_gain = cfg.integ_gain;    mul_x = err_r;  end
      MS_PER:  begin mul_gain = cfg.sample_period; mul_x = qs_r;   end
      MS_KP:   begin mul_gain = cfg.prop_gain;     mul_x = err_r;  end
      MS_KD:   begin mul_gain = cfg.deriv_gain;    mul_x = rate_r; end
      default: begin mul_gain = cfg.integ_gain;    mul_x = err_r;  end
    endcase
  end

  assign mul_a    = {1'b0, mul_gain};
  assign prod_nxt = $signed({{PRD_W{mul_a[PRD_W-1]}}, mul_a}) *
                    $signed({{PRD_W{mul_x[DATA_W-1]}}, mul_x});

  assign shifted = prod_r >>> Q_FRAC;
  assign hi_bits = shifted[2*PRD_W-1:DATA_W-1];
  assign qsat    = ((&hi_bits) || !(|hi_bits)) ? shifted[DATA_W-1:0] :
                   (shifted[2*PRD_W-1] ? Q_MIN : Q_MAX);

  always_comb begin
    isum = {integ_r[DATA_W-1], integ_r} + {qs_r[DATA_W-1], qs_r};
    ilim = {2'b00, cfg.integ_limit};
    if (isum[DATA_W] != isum[DATA_W-1]) begin
      iacc = isum[DATA_W] ? {1'b1, Q_MIN} : {1'b0, Q_MAX};
    end else begin
      iacc = isum;
    end
    iclamp_nxt = 1'b0;
    if (iacc > ilim) begin
      iacc       = ilim;
      iclamp_nxt = 1'b1;
    end else if (iacc < -ilim) begin
      iacc       = -ilim;
      iclamp_nxt = 1'b1;
    end
    integ_nxt = iacc[DATA_W-1:0];
  end

  always_comb begin
    csum = {{2{p_r[DATA_W-1]}}, p_r} - {{2{qs_r[DATA_W-1]}}, qs_r}
         + {{2{integ_r[DATA_W-1]}}, integ_r}
         + {{2{cfg.hover_offset[DATA_W-1]}}, cfg.hover_offset};
    clim = {3'b000, cfg.command_limit};
    oclamp_nxt = 1'b0;
    drive_nxt  = csum[GAIN_W-1:0];
    if (csum > clim) begin
      drive_nxt  = cfg.command_limit;
      oclamp_nxt = 1'b1;
    end else if (csum < 0) begin
      drive_nxt  = '0;
      oclamp_nxt = 1'b1;
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  assign sts.out_busy  = out_valid_r & ~out_ready;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      tgt_r  <= target_alt;
      meas_r <= measured_alt;
      rate_r <= climb_rate;
    end
    if (cmd.err_en) begin
      err_r <= err_nxt;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.sat_en && cmd.sat_to_p) begin
      p_r <= qsat;
    end
    if (cmd.sat_en && !cmd.sat_to_p) begin
      qs_r <= qsat;
    end
    if (cmd.out_load) begin
      drive_r  <= drive_nxt;
      ic_out_r <= iclamp_r;
      oc_out_r <= oclamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      iclamp_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.integ_en) begin
        integ_r  <= integ_nxt;
        iclamp_r <= iclamp_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign drive_command  = drive_r;
  assign integ_clamped  = ic_out_r;
  assign output_clamped = oc_out_r;

endmodule

/* src/altitude_pid_controller.sv */
// Top level of the altitude PID controller: register bank, controller and datapath.
// Depends on apid_pkg, apid_if, apid_regs, apid_ctrl, apid_dp.
//
//  channel  | direction | beat
//  ---------+-----------+------------------------------------------------
//  in_ch    | in        | target_alt, measured_alt, climb_rate (Q16.16)
//  out_ch   | out       | drive_command, integ_clamped, output_clamped
//  APB      | in/out    | 7 registers at byte address 4*i, 32-bit data
//
// The FSM walks 12 states per tick (IDLE, error, four multiply/saturate pairs on
// the one shared 32x32 multiplier, integrator update, sum), so a new beat is
// accepted only once the last tick is through its sum step, where the result
// is loaded into the output register. The output register frees the input side:
// a new beat is taken while the last result waits; the sum step stalls only if
// that result is still not taken. Synchronous active-low reset clears the
// integrator, registers and FSM.
module altitude_pid_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  apid_in_if.sink                     in_ch,
  apid_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apid_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import apid_pkg::*;

  cfg_regs_t cfg;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  apid_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  apid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  apid_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg            (cfg),
    .target_alt     (in_ch.target_alt),
    .measured_alt   (in_ch.measured_alt),
    .climb_rate     (in_ch.climb_rate),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .drive_command  (out_ch.drive_command),
    .integ_clamped  (out_ch.integ_clamped),
    .output_clamped (out_ch.output_clamped)
  );

endmodule

/* src/apid_chk.sv */
// Port-level checker for the altitude PID controller, bound to the top level.
// Depends on apid_pkg for field widths.
module apid_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [apid_pkg::GAIN_W-1:0] drive_command,
  input logic                        pready
);
  import apid_pkg::*;

  // the controller drops ready right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // a fresh result only appears after the block was busy with a tick
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a tick in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(drive_command))
    else $error("stalled result dropped or changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind altitude_pid_controller apid_chk u_apid_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .drive_command (out_ch.drive_command),
  .pready        (pready)
);

/* test/tb_altitude_pid_controller.sv */
`timescale 1ns / 1ps
// Testbench for altitude_pid_controller: directed and random control ticks against a
// cycle-free model of the Q16.16 PID arithmetic, with APB register programming.
// Depends on apid_pkg, apid_if and the RTL under src.
module tb_altitude_pid_controller;
  import apid_pkg::*;

  typedef struct {
    logic [GAIN_W-1:0] command;
    logic              integ_hit;
    logic              cmd_hit;
  } tick_result_t;

  localparam logic [2:0]  IDX_SPARE = 3'd7;   // decoded address with no register behind it
  localparam int          ONE_Q     = 1 << Q_FRAC;
  localparam longint      SAT_HI    = 64'sd2147483647;
  localparam longint      SAT_LO    = -64'sd2147483648;
  localparam int          SETTLE    = 40;

  logic clk = 1'b0;
  logic rst_n;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  apid_in_if  in_ch ();
  apid_out_if out_ch ();

  altitude_pid_controller u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // controller copy: registers and integrator
  logic [GAIN_W-1:0]        kp, ki, kd, ilim, clim, period;
  logic signed [DATA_W-1:0] hover;
  logic signed [DATA_W-1:0] integ_acc;

  tick_result_t expected_ticks[$];
  int           mismatch_count = 0;

  // pacing knobs
  int gap_max    = 0;
  int burst_max  = 0;
  int stall_max  = 0;
  int stall_pct  = 0;
  int burst_left = 0;
  int stall_left = 0;

  function automatic logic signed [31:0] sat_q(input longint v);
    if (v > SAT_HI) return SAT_HI[31:0];
    if (v < SAT_LO) return SAT_LO[31:0];
    return v[31:0];
  endfunction

  // unsigned gain times signed value, floor of the shifted product, saturated
  function automatic logic signed [31:0] gain_mul(input logic [GAIN_W-1:0] gain,
                                                  input logic signed [31:0] x);
    longint prod;
    prod = longint'(gain) * longint'(x);
    return sat_q(prod >>> Q_FRAC);
  endfunction

  function automatic void predict_tick(input logic signed [31:0] target,
                                       input logic signed [31:0] measured,
                                       input logic signed [31:0] rate);
    logic signed [31:0] err, ki_err, incr;
    longint             lim, acc, cmd;
    tick_result_t       r;
    err    = sat_q(longint'(target) - longint'(measured));
    ki_err = gain_mul(ki, err);
    incr   = gain_mul(period, ki_err);
    lim    = longint'(ilim);
    acc    = longint'(sat_q(longint'(integ_acc) + longint'(incr)));
    r.integ_hit = 1'b0;
    r.cmd_hit   = 1'b0;
    if (acc > lim) begin
      acc = lim;
      r.integ_hit = 1'b1;
    end
    if (acc < -lim) begin
      acc = -lim;
      r.integ_hit = 1'b1;
    end
    integ_acc = acc[31:0];
    // full-width sum, high clamp first
    cmd = longint'(gain_mul(kp, err)) - longint'(gain_mul(kd, rate))
        + longint'(integ_acc) + longint'(hover);
    if (cmd > longint'(clim)) begin
      cmd = longint'(clim);
      r.cmd_hit = 1'b1;
    end
    if (cmd < 0) begin
      cmd = 0;
      r.cmd_hit = 1'b1;
    end
    r.command = cmd[GAIN_W-1:0];
    expected_ticks.push_back(r);
  endfunction

  task automatic apb_write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_KP:     kp     = data[GAIN_W-1:0];
      REG_KI:     ki     = data[GAIN_W-1:0];
      REG_KD:     kd     = data[GAIN_W-1:0];
      REG_ILIM:   ilim   = data[GAIN_W-1:0];
      REG_CLIM:   clim   = data[GAIN_W-1:0];
      REG_HOVER:  hover  = data;
      REG_PERIOD: period = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // writes all registers; bit 31 of the 31-bit ones gets noise
  task automatic load_gains(input logic [30:0] p, input logic [30:0] i, input logic [30:0] d,
                            input logic [30:0] il, input logic [30:0] cl,
                            input logic [31:0] hv, input logic [30:0] per);
    apb_write_reg(REG_KP,     {1'($urandom_range(0, 1)), p});
    apb_write_reg(REG_KI,     {1'($urandom_range(0, 1)), i});
    apb_write_reg(REG_KD,     {1'($urandom_range(0, 1)), d});
    apb_write_reg(REG_ILIM,   {1'($urandom_range(0, 1)), il});
    apb_write_reg(REG_CLIM,   {1'($urandom_range(0, 1)), cl});
    apb_write_reg(REG_HOVER,  hv);
    apb_write_reg(REG_PERIOD, {1'($urandom_range(0, 1)), per});
  endtask

  task automatic send_tick(input logic signed [31:0] target, input logic signed [31:0] measured,
                           input logic signed [31:0] rate);
    in_ch.valid        <= 1'b1;
    in_ch.target_alt   <= target;
    in_ch.measured_alt <= measured;
    in_ch.climb_rate   <= rate;
    do @(posedge clk); while (!in_ch.ready);
    predict_tick(target, measured, rate);
    // bursts keep valid high; a gap drops it for a while
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, burst_max);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_pacing(input int gmax, input int bmax, input int smax, input int spct);
    gap_max   = gmax;
    burst_max = bmax;
    stall_max = smax;
    stall_pct = spct;
  endtask

  function automatic logic signed [31:0] near_zero(input int unsigned span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - int'(span);
    return v;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return near_zero(100 * ONE_Q);
    endcase
  endfunction

  function automatic logic [30:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return Q_MAX[30:0];
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 4 * ONE_Q));
    endcase
  endfunction

  function automatic logic [30:0] rand_limit();
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return Q_MAX[30:0];
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 200 * ONE_Q));
    endcase
  endfunction

  // receiver: checks each result beat and stalls on its own pattern
  initial begin
    tick_result_t exp_r;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result beat with no tick pending: drive_command %0d", out_ch.drive_command);
          mismatch_count++;
        end else begin
          exp_r = expected_ticks.pop_front();
          if (out_ch.drive_command !== exp_r.command) begin
            $error("drive_command: expected %0d, actual %0d", exp_r.command,
                   out_ch.drive_command);
            mismatch_count++;
          end
          if (out_ch.integ_clamped !== exp_r.integ_hit) begin
            $error("integ_clamped: expected %0d, actual %0d", exp_r.integ_hit,
                   out_ch.integ_clamped);
            mismatch_count++;
          end
          if (out_ch.output_clamped !== exp_r.cmd_hit) begin
            $error("output_clamped: expected %0d, actual %0d", exp_r.cmd_hit,
                   out_ch.output_clamped);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_max > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, stall_max) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // reset values: all gains zero, default period
  task automatic test_reset_values();
    set_pacing(3, 2, 4, 30);
    send_tick(Q_MAX, Q_MIN, Q_MIN);
    send_tick(near_zero(ONE_Q), 32'sd0, Q_MAX);
    wait_drained();
  endtask

  // error saturation in both directions and rate extremes at unit gains
  task automatic test_error_extremes();
    load_gains(31'(ONE_Q), 31'(ONE_Q), 31'(ONE_Q), Q_MAX[30:0], Q_MAX[30:0], 32'sd0,
               PERIOD_RESET);
    set_pacing(0, 0, 0, 0);
    send_tick(Q_MAX, Q_MIN, 32'sd0);
    send_tick(Q_MIN, Q_MAX, 32'sd0);
    send_tick(32'sd0, 32'sd0, Q_MAX);
    send_tick(32'sd0, 32'sd0, Q_MIN);
    send_tick(-32'sd1, 32'sd0, 32'sd1);
    send_tick(32'sd0, 32'sd0, 32'sd0);
    wait_drained();
  endtask

  // integrator driven into both clamps
  task automatic test_integrator_clamp();
    load_gains(31'd0, 31'(100 * ONE_Q), 31'd0, 31'(5 * ONE_Q), 31'(50 * ONE_Q), 10 * ONE_Q,
               31'(ONE_Q / 2));
    set_pacing(2, 1, 3, 40);
    send_tick(3 * ONE_Q, 32'sd0, 32'sd0);
    send_tick(3 * ONE_Q, 32'sd0, 32'sd0);
    send_tick(-(3 * ONE_Q), 32'sd0, 32'sd0);
    send_tick(Q_MIN, Q_MAX, 32'sd0);
    wait_drained();
  endtask

  // command clamp high, low, inside, and full-width sum with extreme offsets
  task automatic test_command_clamp();
    load_gains(31'(2 * ONE_Q), 31'd0, 31'(ONE_Q), 31'd0, 31'(10 * ONE_Q), -(3 * ONE_Q),
               PERIOD_RESET);
    set_pacing(1, 3, 2, 50);
    send_tick(100 * ONE_Q, 32'sd0, 32'sd0);
    send_tick(-(100 * ONE_Q), 32'sd0, 32'sd0);
    send_tick(3 * ONE_Q, 32'sd0, ONE_Q);
    wait_drained();
    load_gains(Q_MAX[30:0], 31'd0, Q_MAX[30:0], 31'd0, Q_MAX[30:0], Q_MAX, 31'd0);
    send_tick(Q_MAX, Q_MIN, Q_MIN);
    send_tick(Q_MIN, Q_MAX, Q_MAX);
    wait_drained();
    apb_write_reg(REG_HOVER, Q_MIN);
    send_tick(Q_MAX, Q_MIN, Q_MIN);
    send_tick(32'sd0, 32'sd0, 32'sd0);
    wait_drained();
  endtask

  // upper bits of the 31-bit registers masked, spare address ignored
  task automatic test_register_masking();
    apb_write_reg(REG_KP,     32'h8000_0000 | ONE_Q);
    apb_write_reg(REG_KI,     32'hFFFF_FFFF);
    apb_write_reg(REG_KD,     32'h8000_8000);
    apb_write_reg(REG_ILIM,   32'h8000_0000 | (20 * ONE_Q));
    apb_write_reg(REG_CLIM,   32'hFFFF_FFFF);
    apb_write_reg(REG_HOVER,  32'h8000_0000 | ONE_Q);
    apb_write_reg(REG_PERIOD, 32'h8000_0000 | PERIOD_RESET);
    apb_write_reg(IDX_SPARE,  $urandom);
    set_pacing(4, 1, 6, 20);
    send_tick(5 * ONE_Q, ONE_Q, 2 * ONE_Q);
    send_tick(-(5 * ONE_Q), ONE_Q, -(2 * ONE_Q));
    send_tick(Q_MAX, 32'sd0, -32'sd1);
    wait_drained();
  endtask

  // random settings per phase, extremes first, then random ticks
  task automatic test_random_phases();
    logic signed [31:0] target, measured;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: load_gains(Q_MAX[30:0], Q_MAX[30:0], Q_MAX[30:0], Q_MAX[30:0], Q_MAX[30:0],
                      Q_MAX, Q_MAX[30:0]);
        1: load_gains(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, Q_MIN, 31'd0);
        default: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit(),
                            ($urandom_range(0, 3) == 0) ? rand_q() :
                              32'($urandom_range(0, 60 * ONE_Q)),
                            ($urandom_range(0, 2) == 0) ? rand_gain() : PERIOD_RESET);
      endcase
      if (phase == 2)
        set_pacing(0, 0, 0, 0);
      else
        set_pacing($urandom_range(0, 16), $urandom_range(0, 8), $urandom_range(0, 24),
                   $urandom_range(10, 60));
      for (int n = 0; n < 45; n++) begin
        target   = rand_q();
        measured = ($urandom_range(0, 3) == 0) ? rand_q() : target + near_zero(5 * ONE_Q);
        send_tick(target, measured, rand_q());
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.target_alt   <= '0;
    in_ch.measured_alt <= '0;
    in_ch.climb_rate   <= '0;
    kp        = '0;
    ki        = '0;
    kd        = '0;
    ilim      = '0;
    clim      = '0;
    hover     = '0;
    period    = PERIOD_RESET;
    integ_acc = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_error_extremes();
    test_integrator_clamp();
    test_command_clamp();
    test_register_masking();
    test_random_phases();

    set_pacing(0, 0, 0, 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
src/apid_pkg.sv
src/apid_if.sv
src/apid_regs.sv
src/apid_ctrl.sv
src/apid_dp.sv
src/altitude_pid_controller.sv
src/apid_chk.sv
test/tb_altitude_pid_controller.sv
